// ===== rtl/bbs_pkg.sv =====
// ----------------------------------------------------------------------------
// bbs_pkg
// shared types and constants for the block bit scrambler
// ----------------------------------------------------------------------------
`default_nettype none

package bbs_pkg;

  // most results one item may cause, and the width of a bit count up to it
  localparam int RESULT_CAP    = 64;
  localparam int LEN_W         = 7;
  localparam int MAX_BLOCK_DEF = 64;

  // register file
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam int SIZE_W  = 7;
  localparam logic REG_MODE       = 1'b0;
  localparam logic REG_BLOCK_SIZE = 1'b1;
  localparam logic [SIZE_W-1:0] BLOCK_SIZE_RST = SIZE_W'(4);

  localparam logic MODE_INVERT = 1'b0;
  localparam logic MODE_ROTATE = 1'b1;

  // what the back end does with a block
  typedef enum logic [1:0] {
    OP_PASS,
    OP_INVERT,
    OP_ROTATE
  } op_t;

  // inversion pattern in invert mode
  typedef enum logic [1:0] {
    FLIP_ALL,
    FLIP_SECOND,
    FLIP_THIRD
  } flip_t;

  typedef struct packed {
    logic data_bit;
    logic stream_end;
  } in_item_t;

  typedef struct packed {
    logic out_bit;
    logic run_last;
    logic out_stream_end;
  } out_item_t;

  // one finished block waiting for the back end
  typedef struct packed {
    logic             buf_sel;
    logic [LEN_W-1:0] len;
    op_t              op;
    flip_t            flip;
    logic             stream_end;
  } desc_t;

  typedef struct packed {
    logic       full;
    logic       empty;
    logic [1:0] count;
  } q_status_t;

endpackage

`default_nettype wire

// ===== rtl/block_bit_scrambler_core.sv =====
// order: a block is read out once its last input bit has queued it, through the
//   memory read and output registers; throughput: one input bit per cycle
//   while the queue is not full; the block memory has one read port, so the
//   back end emits one bit per cycle from two block buffers unless stalled
// reset: control state clears synchronously; block memory is not cleared
// ----------------------------------------------------------------------------
// block_bit_scrambler_core
// cuts a bit stream into blocks, emits a short last block as is and full ones inverted or rotated
// ----------------------------------------------------------------------------
`default_nettype none

module block_bit_scrambler_core #(
  parameter int MAX_BLOCK = bbs_pkg::MAX_BLOCK_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // register port
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [bbs_pkg::PADDR_W-1:0] paddr,
  input  wire logic [bbs_pkg::PDATA_W-1:0] pwdata,
  output logic      [bbs_pkg::PDATA_W-1:0] prdata,
  output logic                             pready,
  // stream bits in
  input  wire logic                        data_valid,
  output logic                             data_stall,
  input  wire bbs_pkg::in_item_t           data,
  // encoded bits out
  output logic                             code_valid,
  input  wire logic                        code_stall,
  output bbs_pkg::out_item_t               code
);

  localparam int CAP = (MAX_BLOCK < bbs_pkg::RESULT_CAP) ? MAX_BLOCK : bbs_pkg::RESULT_CAP;
  localparam int AW  = $clog2(CAP);

  // configuration registers
  logic                      mode;
  logic [bbs_pkg::SIZE_W-1:0] block_size;
  logic                      cfg_wr;

  // front to back
  logic                      accept;
  logic                      wr_en;
  logic [AW:0]               wr_addr;
  logic                      wr_bit;
  logic                      push;
  bbs_pkg::desc_t            push_desc;
  logic                      pop;
  bbs_pkg::desc_t            head;
  bbs_pkg::q_status_t        q_status;

  // register port: always ready, decoded on the word address bit
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= bbs_pkg::MODE_INVERT;
      block_size <= bbs_pkg::BLOCK_SIZE_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        bbs_pkg::REG_MODE:       mode       <= pwdata[0];
        bbs_pkg::REG_BLOCK_SIZE: block_size <= pwdata[bbs_pkg::SIZE_W-1:0];
        default:                 mode       <= mode;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      bbs_pkg::REG_MODE:       prdata = bbs_pkg::PDATA_W'(mode);
      bbs_pkg::REG_BLOCK_SIZE: prdata = bbs_pkg::PDATA_W'(block_size);
      default:                 prdata = '0;
    endcase
  end

  // input stalls only while both block buffers hold blocks not yet read out
  assign data_stall = q_status.full;
  assign accept     = data_valid && !data_stall;

  // front: fills the current buffer, counts ones, classifies full blocks
  bbs_front #(
    .MAX_BLOCK (MAX_BLOCK)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .mode       (mode),
    .block_size (block_size),
    .accept     (accept),
    .item       (data),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_bit     (wr_bit),
    .push       (push),
    .push_desc  (push_desc)
  );

  // queue of finished blocks; an entry is released once its last bit is read
  bbs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  // back: reads the head block out through the memory and output register
  bbs_back #(
    .MAX_BLOCK (MAX_BLOCK)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_bit     (wr_bit),
    .head       (head),
    .head_valid (!q_status.empty),
    .pop        (pop),
    .out_valid  (code_valid),
    .out_stall  (code_stall),
    .out_item   (code)
  );

  // queue never overflows and never underflows
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    !(push && q_status.full))
    else $error("block pushed into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_status.empty)
    else $error("block released from empty queue");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    q_status.count != 2'd3)
    else $error("queue count out of range");

  // the final bit of a stream always closes a block
  a_end_closes: assert property (@(posedge clk) disable iff (rst)
    (code_valid && code.out_stream_end) |-> code.run_last)
    else $error("stream end on a bit that does not close its block");

endmodule

`default_nettype wire

// ===== rtl/bbs_front.sv =====
// ----------------------------------------------------------------------------
// bbs_front
// takes stream bits, fills the block buffers and classifies each finished block
// ----------------------------------------------------------------------------
`default_nettype none

module bbs_front #(
  parameter int MAX_BLOCK = bbs_pkg::MAX_BLOCK_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       mode,
  input  wire logic [bbs_pkg::SIZE_W-1:0] block_size,
  input  wire logic                       accept,
  input  wire bbs_pkg::in_item_t          item,
  output logic                            wr_en,
  output logic [$clog2((MAX_BLOCK < bbs_pkg::RESULT_CAP) ? MAX_BLOCK :
                bbs_pkg::RESULT_CAP):0]    wr_addr,
  output logic                            wr_bit,
  output logic                            push,
  output bbs_pkg::desc_t                  push_desc
);

  localparam int CAP = (MAX_BLOCK < bbs_pkg::RESULT_CAP) ? MAX_BLOCK : bbs_pkg::RESULT_CAP;
  localparam int AW  = $clog2(CAP);
  localparam int LW  = bbs_pkg::LEN_W;

  logic                 wr_buf, wr_buf_next;
  logic [LW-1:0]        fill, fill_next;
  logic [LW-1:0]        ones, ones_next;
  bbs_pkg::flip_t       flip_step, flip_step_next;

  logic [LW-1:0]        size_eff;
  logic [LW-1:0]        len;
  logic [LW-1:0]        ones_new;
  logic [LW-1:0]        zeros;
  logic                 full;
  bbs_pkg::flip_t       flip_new;

  // clamp the configured size into the supported range
  always_comb begin
    if (block_size < bbs_pkg::SIZE_W'(3)) begin
      size_eff = LW'(3);
    end else if (LW'(block_size) > LW'(CAP)) begin
      size_eff = LW'(CAP);
    end else begin
      size_eff = LW'(block_size);
    end
  end

  assign len      = fill + LW'(1);
  assign ones_new = ones + LW'(item.data_bit);
  assign zeros    = len - ones_new;
  assign full     = (len >= size_eff);

  always_comb begin
    if (ones_new == zeros) begin
      flip_new = bbs_pkg::FLIP_ALL;
    end else if (zeros > ones_new) begin
      flip_new = bbs_pkg::FLIP_SECOND;
    end else begin
      flip_new = bbs_pkg::FLIP_THIRD;
    end
  end

  assign wr_en   = accept;
  assign wr_addr = {wr_buf, fill[AW-1:0]};
  assign wr_bit  = item.data_bit;
  assign push    = accept && (full || item.stream_end);

  always_comb begin
    push_desc.buf_sel    = wr_buf;
    push_desc.len        = len;
    push_desc.flip       = flip_step;
    push_desc.stream_end = item.stream_end;
    if (!full) begin
      push_desc.op = bbs_pkg::OP_PASS;
    end else if (mode == bbs_pkg::MODE_ROTATE) begin
      push_desc.op = bbs_pkg::OP_ROTATE;
    end else begin
      push_desc.op = bbs_pkg::OP_INVERT;
    end
  end

  always_comb begin
    wr_buf_next    = wr_buf;
    fill_next      = fill;
    ones_next      = ones;
    flip_step_next = flip_step;
    if (push) begin
      wr_buf_next    = ~wr_buf;
      fill_next      = '0;
      ones_next      = '0;
      flip_step_next = item.stream_end ? bbs_pkg::FLIP_ALL : flip_new;
    end else if (accept) begin
      fill_next = len;
      ones_next = ones_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_buf    <= 1'b0;
      fill      <= '0;
      ones      <= '0;
      flip_step <= bbs_pkg::FLIP_ALL;
    end else begin
      wr_buf    <= wr_buf_next;
      fill      <= fill_next;
      ones      <= ones_next;
      flip_step <= flip_step_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bbs_queue.sv =====
// ----------------------------------------------------------------------------
// bbs_queue
// two-entry queue of finished blocks between front and back end
// ----------------------------------------------------------------------------
`default_nettype none

module bbs_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire bbs_pkg::desc_t  push_desc,
  input  wire logic            pop,
  output bbs_pkg::desc_t       head,
  output bbs_pkg::q_status_t   status
);

  bbs_pkg::desc_t entry [2];
  logic           wr_ptr, rd_ptr;
  logic [1:0]     count, count_next;

  assign head          = entry[rd_ptr];
  assign status.count  = count;
  assign status.full   = (count == 2'd2);
  assign status.empty  = (count == 2'd0);

  always_comb begin
    unique case ({push, pop})
      2'b10:   count_next = count + 2'd1;
      2'b01:   count_next = count - 2'd1;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_desc;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bbs_back.sv =====
// ----------------------------------------------------------------------------
// bbs_back
// block memory and the emitter that reads a block out one bit per cycle while the output is not stalled
// ----------------------------------------------------------------------------
`default_nettype none

module bbs_back #(
  parameter int MAX_BLOCK = bbs_pkg::MAX_BLOCK_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 wr_en,
  input  wire logic [$clog2((MAX_BLOCK < bbs_pkg::RESULT_CAP) ? MAX_BLOCK :
                     bbs_pkg::RESULT_CAP):0] wr_addr,
  input  wire logic                 wr_bit,
  input  wire bbs_pkg::desc_t       head,
  input  wire logic                 head_valid,
  output logic                      pop,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output bbs_pkg::out_item_t        out_item
);

  localparam int CAP   = (MAX_BLOCK < bbs_pkg::RESULT_CAP) ? MAX_BLOCK : bbs_pkg::RESULT_CAP;
  localparam int AW    = $clog2(CAP);
  localparam int DEPTH = 2 ** (AW + 1);
  localparam int LW    = bbs_pkg::LEN_W;

  logic          mem [DEPTH];

  logic [LW-1:0] idx;
  logic [1:0]    m3;
  logic [LW-1:0] idx_sel;
  logic [AW:0]   rd_addr;
  logic          issue;
  logic          last;
  logic          inv;
  logic          out_adv;

  logic          s1_valid;
  logic          rd_bit;
  logic          s1_inv;
  logic          s1_last;
  logic          s1_end;

  assign out_adv = !out_valid || !out_stall;
  assign issue   = head_valid && (!s1_valid || out_adv);
  assign last    = (idx == head.len - LW'(1));
  assign pop     = issue && last;

  // rotate right: position 0 takes the last bit, others the one before
  always_comb begin
    unique case (head.op)
      bbs_pkg::OP_ROTATE: idx_sel = (idx == '0) ? head.len - LW'(1) : idx - LW'(1);
      default:            idx_sel = idx;
    endcase
  end

  assign rd_addr = {head.buf_sel, idx_sel[AW-1:0]};

  always_comb begin
    inv = 1'b0;
    if (head.op == bbs_pkg::OP_INVERT) begin
      unique case (head.flip)
        bbs_pkg::FLIP_ALL:    inv = 1'b1;
        bbs_pkg::FLIP_SECOND: inv = idx[0];
        bbs_pkg::FLIP_THIRD:  inv = (m3 == 2'd2);
        default:              inv = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_bit;
    end
    if (issue) begin
      rd_bit <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      m3        <= 2'd0;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (issue) begin
        idx <= last ? '0 : idx + LW'(1);
        m3  <= (last || m3 == 2'd2) ? 2'd0 : m3 + 2'd1;
      end
      s1_valid <= issue || (s1_valid && !out_adv);
      if (out_adv) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_inv  <= inv;
      s1_last <= last;
      s1_end  <= last && head.stream_end;
    end
    if (out_adv && s1_valid) begin
      out_item.out_bit        <= rd_bit ^ s1_inv;
      out_item.run_last       <= s1_last;
      out_item.out_stream_end <= s1_end;
    end
  end

endmodule

`default_nettype wire
